[rtl/pea_pkg.sv]
`default_nettype none
package pea_pkg;

    // operation codes
    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_ADDU   = 6'd1;
    localparam logic [5:0] OP_ADDIU  = 6'd2;
    localparam logic [5:0] OP_SUB    = 6'd3;
    localparam logic [5:0] OP_SUBU   = 6'd4;
    localparam logic [5:0] OP_MUL    = 6'd5;
    localparam logic [5:0] OP_MULU   = 6'd6;
    localparam logic [5:0] OP_DIV    = 6'd7;
    localparam logic [5:0] OP_DIVU   = 6'd8;
    localparam logic [5:0] OP_XOR    = 6'd9;
    localparam logic [5:0] OP_XORU   = 6'd10;
    localparam logic [5:0] OP_NEG    = 6'd11;
    localparam logic [5:0] OP_NEGU   = 6'd12;
    localparam logic [5:0] OP_REM    = 6'd13;
    localparam logic [5:0] OP_REMU   = 6'd14;
    localparam logic [5:0] OP_LI     = 6'd15;
    localparam logic [5:0] OP_SEQ    = 6'd16;
    localparam logic [5:0] OP_SGE    = 6'd17;
    localparam logic [5:0] OP_SGT    = 6'd18;
    localparam logic [5:0] OP_SLE    = 6'd19;
    localparam logic [5:0] OP_SLT    = 6'd20;
    localparam logic [5:0] OP_SNE    = 6'd21;
    localparam logic [5:0] OP_B      = 6'd22;
    localparam logic [5:0] OP_BEQ    = 6'd23;
    localparam logic [5:0] OP_BNE    = 6'd24;
    localparam logic [5:0] OP_BGE    = 6'd25;
    localparam logic [5:0] OP_BLE    = 6'd26;
    localparam logic [5:0] OP_BGT    = 6'd27;
    localparam logic [5:0] OP_BLT    = 6'd28;
    localparam logic [5:0] OP_BEQZ   = 6'd29;
    localparam logic [5:0] OP_BNEZ   = 6'd30;
    localparam logic [5:0] OP_BLEZ   = 6'd31;
    localparam logic [5:0] OP_BGEZ   = 6'd32;
    localparam logic [5:0] OP_BGTZ   = 6'd33;
    localparam logic [5:0] OP_BLTZ   = 6'd34;
    localparam logic [5:0] OP_J      = 6'd35;
    localparam logic [5:0] OP_JR     = 6'd36;
    localparam logic [5:0] OP_JAL    = 6'd37;
    localparam logic [5:0] OP_JALR   = 6'd38;
    localparam logic [5:0] OP_LA     = 6'd39;
    localparam logic [5:0] OP_LB     = 6'd40;
    localparam logic [5:0] OP_LH     = 6'd41;
    localparam logic [5:0] OP_LW     = 6'd42;
    localparam logic [5:0] OP_SB     = 6'd43;
    localparam logic [5:0] OP_SH     = 6'd44;
    localparam logic [5:0] OP_SW     = 6'd45;
    localparam logic [5:0] OP_MOVE   = 6'd46;
    localparam logic [5:0] OP_MFHI   = 6'd47;
    localparam logic [5:0] OP_MFLO   = 6'd48;
    localparam logic [5:0] OP_BUBBLE = 6'd49;

    // destination codes
    localparam logic [5:0] CODE_NONE = 6'b111101;
    localparam logic [5:0] CODE_JUMP = 6'b111110;

    localparam logic [31:0] NO_LINK  = 32'hffffffff;

    localparam int unsigned DIV_ST = 32;

    // control carried down the pipe with each item
    typedef struct packed {
        logic [5:0]  code;
        logic [31:0] p;
        logic [31:0] s;
        logic        is_mul;
        logic        is_div;
        logic        is_rem;
        logic        want_s;
        logic        neg_q;
        logic        neg_r;
        logic        dz;
    } t_ctl;

endpackage
`default_nettype wire

[rtl/pipeline_execute_alu.sv]
// pipeline of 35 registers (input reg, decode/multiply, 32 radix-2 divide stages, output reg);
// one quotient bit per stage sets the depth
// throughput: one item per cycle; the whole pipe holds when a result waits untaken
// reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset
`default_nettype none
module pipeline_execute_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [5:0]  i_operation,
    input  wire logic signed [31:0] i_dest_field,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    input  wire logic signed [31:0] i_label_target,
    input  wire logic signed [31:0] i_hi_value,
    input  wire logic signed [31:0] i_lo_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [5:0]  o_dest_code,
    output logic signed [31:0] o_primary_result,
    output logic signed [31:0] o_secondary_result,
    output logic             o_divide_by_zero
);

    // pipe advances as a whole
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // input register
    logic        r_a_valid;
    logic [5:0]  r_a_op;
    logic [31:0] r_a_d, r_a_a, r_a_b, r_a_l, r_a_h, r_a_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
        if (en) begin
            r_a_op <= i_operation;
            r_a_d  <= i_dest_field;
            r_a_a  <= i_operand_a;
            r_a_b  <= i_operand_b;
            r_a_l  <= i_label_target;
            r_a_h  <= i_hi_value;
            r_a_lo <= i_lo_value;
        end
    end

    // decode, simple results, multiply and divider setup
    pea_pkg::t_ctl n_b_ctl;
    logic [63:0]   n_b_prod;
    logic [31:0]   n_b_ua, n_b_ub;
    logic [31:0]   sum, addr;
    logic          eq, lt, az, taken, sgn;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;

    always_comb begin
        sum   = r_a_a + r_a_b;
        addr  = r_a_a[31] ? r_a_l : sum;
        eq    = (r_a_a == r_a_b);
        lt    = ($signed(r_a_a) < $signed(r_a_b));
        az    = (r_a_a == 32'd0);
        sgn   = (r_a_op == pea_pkg::OP_MUL) || (r_a_op == pea_pkg::OP_DIV) ||
                (r_a_op == pea_pkg::OP_REM);
        mul_a = {sgn & r_a_a[31], r_a_a};
        mul_b = {sgn & r_a_b[31], r_a_b};
        prod_full = 66'(mul_a) * 66'(mul_b);
        n_b_prod  = prod_full[63:0];

        // branch condition
        unique case (r_a_op)
            pea_pkg::OP_BEQ:  taken = eq;
            pea_pkg::OP_BNE:  taken = !eq;
            pea_pkg::OP_BGE:  taken = !lt;
            pea_pkg::OP_BLE:  taken = lt || eq;
            pea_pkg::OP_BGT:  taken = !lt && !eq;
            pea_pkg::OP_BLT:  taken = lt;
            pea_pkg::OP_BEQZ: taken = az;
            pea_pkg::OP_BNEZ: taken = !az;
            pea_pkg::OP_BLEZ: taken = r_a_a[31] || az;
            pea_pkg::OP_BGEZ: taken = !r_a_a[31];
            pea_pkg::OP_BGTZ: taken = !r_a_a[31] && !az;
            default:          taken = r_a_a[31];
        endcase

        n_b_ctl        = '0;
        n_b_ctl.want_s = r_a_d[31];
        n_b_ctl.code   = ($signed(r_a_d) < -32'sd1 || $signed(r_a_d) > 32'sd31)
                         ? pea_pkg::CODE_NONE : r_a_d[5:0];
        n_b_ua = (sgn && r_a_a[31]) ? (32'd0 - r_a_a) : r_a_a;
        n_b_ub = (sgn && r_a_b[31]) ? (32'd0 - r_a_b) : r_a_b;

        unique case (r_a_op)
            pea_pkg::OP_ADD, pea_pkg::OP_ADDU, pea_pkg::OP_ADDIU: n_b_ctl.p = sum;
            pea_pkg::OP_SUB, pea_pkg::OP_SUBU: n_b_ctl.p = r_a_a - r_a_b;
            pea_pkg::OP_MUL, pea_pkg::OP_MULU: n_b_ctl.is_mul = 1'b1;
            pea_pkg::OP_DIV, pea_pkg::OP_DIVU, pea_pkg::OP_REM, pea_pkg::OP_REMU: begin
                n_b_ctl.is_div = 1'b1;
                n_b_ctl.is_rem = (r_a_op == pea_pkg::OP_REM) || (r_a_op == pea_pkg::OP_REMU);
                n_b_ctl.dz     = (r_a_b == 32'd0);
                n_b_ctl.neg_q  = sgn && (r_a_a[31] ^ r_a_b[31]);
                n_b_ctl.neg_r  = sgn && r_a_a[31];
            end
            pea_pkg::OP_XOR, pea_pkg::OP_XORU: n_b_ctl.p = r_a_a ^ r_a_b;
            pea_pkg::OP_NEG, pea_pkg::OP_NEGU: n_b_ctl.p = 32'd0 - r_a_a;
            pea_pkg::OP_LI:   n_b_ctl.p = r_a_b;
            pea_pkg::OP_SEQ:  n_b_ctl.p = {31'd0, eq};
            pea_pkg::OP_SGE:  n_b_ctl.p = {31'd0, !lt};
            pea_pkg::OP_SGT:  n_b_ctl.p = {31'd0, !lt && !eq};
            pea_pkg::OP_SLE:  n_b_ctl.p = {31'd0, lt || eq};
            pea_pkg::OP_SLT:  n_b_ctl.p = {31'd0, lt};
            pea_pkg::OP_SNE:  n_b_ctl.p = {31'd0, !eq};
            pea_pkg::OP_B, pea_pkg::OP_J: begin
                n_b_ctl.code = pea_pkg::CODE_JUMP;
                n_b_ctl.p    = pea_pkg::NO_LINK;
                n_b_ctl.s    = r_a_l;
            end
            pea_pkg::OP_BEQ, pea_pkg::OP_BNE, pea_pkg::OP_BGE, pea_pkg::OP_BLE,
            pea_pkg::OP_BGT, pea_pkg::OP_BLT, pea_pkg::OP_BEQZ, pea_pkg::OP_BNEZ,
            pea_pkg::OP_BLEZ, pea_pkg::OP_BGEZ, pea_pkg::OP_BGTZ, pea_pkg::OP_BLTZ: begin
                n_b_ctl.code = pea_pkg::CODE_JUMP;
                n_b_ctl.p    = pea_pkg::NO_LINK;
                n_b_ctl.s    = taken ? r_a_l : r_a_d;
            end
            pea_pkg::OP_JR: begin
                n_b_ctl.code = pea_pkg::CODE_JUMP;
                n_b_ctl.p    = pea_pkg::NO_LINK;
                n_b_ctl.s    = r_a_a;
            end
            pea_pkg::OP_JAL: begin
                n_b_ctl.code = pea_pkg::CODE_JUMP;
                n_b_ctl.p    = r_a_b;
                n_b_ctl.s    = r_a_l;
            end
            pea_pkg::OP_JALR: begin
                n_b_ctl.code = pea_pkg::CODE_JUMP;
                n_b_ctl.p    = r_a_b;
                n_b_ctl.s    = r_a_a;
            end
            pea_pkg::OP_LA: begin
                n_b_ctl.p = addr;
                n_b_ctl.s = addr;
            end
            pea_pkg::OP_LB, pea_pkg::OP_LH, pea_pkg::OP_LW: n_b_ctl.s = addr;
            pea_pkg::OP_SB, pea_pkg::OP_SH, pea_pkg::OP_SW: begin
                n_b_ctl.code = pea_pkg::CODE_NONE;
                n_b_ctl.p    = r_a_d;
                n_b_ctl.s    = addr;
            end
            pea_pkg::OP_MOVE: n_b_ctl.p = r_a_a;
            pea_pkg::OP_MFHI: n_b_ctl.p = r_a_h;
            pea_pkg::OP_MFLO: n_b_ctl.p = r_a_lo;
            default:          n_b_ctl.code = pea_pkg::CODE_NONE;
        endcase
    end

    // decode register
    logic          r_b_valid;
    pea_pkg::t_ctl r_b_ctl;
    logic [63:0]   r_b_prod;
    logic [31:0]   r_b_ua, r_b_ub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_b_ctl  <= n_b_ctl;
            r_b_prod <= n_b_prod;
            r_b_ua   <= n_b_ua;
            r_b_ub   <= n_b_ub;
        end
    end

    // divider entry: fold the product into the result words
    pea_pkg::t_ctl entry_ctl;
    always_comb begin
        entry_ctl = r_b_ctl;
        if (r_b_ctl.is_mul) begin
            entry_ctl.p = r_b_prod[31:0];
            entry_ctl.s = r_b_ctl.want_s ? r_b_prod[63:32] : 32'd0;
        end
    end

    // radix-2 restoring divide, one quotient bit per stage
    logic          r_d_valid [pea_pkg::DIV_ST];
    pea_pkg::t_ctl r_d_ctl   [pea_pkg::DIV_ST];
    logic [63:0]   r_d_rq    [pea_pkg::DIV_ST];
    logic [31:0]   r_d_dvs   [pea_pkg::DIV_ST];
    logic [63:0]   n_d_rq    [pea_pkg::DIV_ST];

    // stage inputs: the first stage takes the decode register
    logic          d_in_valid [pea_pkg::DIV_ST];
    pea_pkg::t_ctl d_in_ctl   [pea_pkg::DIV_ST];
    logic [63:0]   d_in_rq    [pea_pkg::DIV_ST];
    logic [31:0]   d_in_dvs   [pea_pkg::DIV_ST];

    always_comb begin
        d_in_valid[0] = r_b_valid;
        d_in_ctl[0]   = entry_ctl;
        d_in_rq[0]    = {32'd0, r_b_ua};
        d_in_dvs[0]   = r_b_ub;
        for (int k = 1; k < int'(pea_pkg::DIV_ST); k++) begin
            d_in_valid[k] = r_d_valid[k-1];
            d_in_ctl[k]   = r_d_ctl[k-1];
            d_in_rq[k]    = r_d_rq[k-1];
            d_in_dvs[k]   = r_d_dvs[k-1];
        end
    end

    always_comb begin
        logic [32:0] t;
        logic        ge;
        for (int k = 0; k < int'(pea_pkg::DIV_ST); k++) begin
            t   = d_in_rq[k][63:31];
            ge  = (t >= {1'b0, d_in_dvs[k]});
            n_d_rq[k] = {ge ? 32'(t - {1'b0, d_in_dvs[k]}) : t[31:0], d_in_rq[k][30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < int'(pea_pkg::DIV_ST); k++) begin
            if (!i_rst_n) begin
                r_d_valid[k] <= 1'b0;
            end else if (en) begin
                r_d_valid[k] <= d_in_valid[k];
            end
            if (en) begin
                r_d_ctl[k] <= d_in_ctl[k];
                r_d_dvs[k] <= d_in_dvs[k];
                r_d_rq[k]  <= n_d_rq[k];
            end
        end
    end

    // sign fix-up and final selection
    pea_pkg::t_ctl last_ctl;
    logic [31:0]   quo, rem, n_p, n_s;
    always_comb begin
        last_ctl = r_d_ctl[pea_pkg::DIV_ST-1];
        quo = r_d_rq[pea_pkg::DIV_ST-1][31:0];
        rem = r_d_rq[pea_pkg::DIV_ST-1][63:32];
        if (last_ctl.neg_q) quo = 32'd0 - quo;
        if (last_ctl.neg_r) rem = 32'd0 - rem;
        n_p = last_ctl.p;
        n_s = last_ctl.s;
        if (last_ctl.is_div) begin
            if (last_ctl.dz) begin
                n_p = 32'd0;
                n_s = 32'd0;
            end else if (last_ctl.is_rem) begin
                n_p = rem;
                n_s = 32'd0;
            end else begin
                n_p = quo;
                n_s = last_ctl.want_s ? rem : 32'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_d_valid[pea_pkg::DIV_ST-1];
        end
        if (en) begin
            o_dest_code        <= last_ctl.code;
            o_primary_result   <= n_p;
            o_secondary_result <= n_s;
            o_divide_by_zero   <= last_ctl.dz;
        end
    end

endmodule
`default_nettype wire

[test/tb_pipeline_execute_alu.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_pipeline_execute_alu;

    localparam int PIPE_DEPTH  = 35;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1350;

    typedef struct packed {
        logic [5:0]  code;
        logic [31:0] p;
        logic [31:0] s;
        logic        dz;
    } t_alu_result;

    // expected execute results, oldest first
    class alu_scoreboard;
        t_alu_result pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // predicted destination code for a register write
        function logic [5:0] write_code(logic signed [31:0] d);
            if (d < -1 || d > 31) return pea_pkg::CODE_NONE;
            return d[5:0];
        endfunction

        function logic branch_cond(logic [5:0] op, logic signed [31:0] a,
                                   logic signed [31:0] b);
            unique case (op)
                pea_pkg::OP_BEQ:  return a == b;
                pea_pkg::OP_BNE:  return a != b;
                pea_pkg::OP_BGE:  return a >= b;
                pea_pkg::OP_BLE:  return a <= b;
                pea_pkg::OP_BGT:  return a > b;
                pea_pkg::OP_BLT:  return a < b;
                pea_pkg::OP_BEQZ: return a == 0;
                pea_pkg::OP_BNEZ: return a != 0;
                pea_pkg::OP_BLEZ: return a <= 0;
                pea_pkg::OP_BGEZ: return a >= 0;
                pea_pkg::OP_BGTZ: return a > 0;
                default: return a < 0;
            endcase
        endfunction

        // note an accepted instruction and predict its result
        function void note_instr(logic [5:0] op, logic signed [31:0] d,
                                 logic signed [31:0] a, logic signed [31:0] b,
                                 logic signed [31:0] lbl, logic signed [31:0] hi,
                                 logic signed [31:0] lo);
            t_alu_result r;
            logic signed [63:0] sprod;
            logic [63:0] uprod;
            logic [31:0] q, rm, addr;
            r.code = write_code(d);
            r.p = '0;
            r.s = '0;
            r.dz = 1'b0;
            addr = (a < 0) ? lbl : a + b;
            if (a == 32'sh80000000 && b == -1) begin
                q = 32'h80000000;
                rm = '0;
            end else if (b != 0) begin
                q = a / b;
                rm = a % b;
            end
            unique case (op)
                pea_pkg::OP_ADD, pea_pkg::OP_ADDU, pea_pkg::OP_ADDIU: r.p = a + b;
                pea_pkg::OP_SUB, pea_pkg::OP_SUBU: r.p = a - b;
                pea_pkg::OP_MUL: begin
                    sprod = 64'(a) * 64'(b);
                    r.p = sprod[31:0];
                    if (d < 0) r.s = sprod[63:32];
                end
                pea_pkg::OP_MULU: begin
                    uprod = {32'b0, a} * {32'b0, b};
                    r.p = uprod[31:0];
                    if (d < 0) r.s = uprod[63:32];
                end
                pea_pkg::OP_DIV, pea_pkg::OP_REM: begin
                    if (b == 0) r.dz = 1'b1;
                    else if (op == pea_pkg::OP_REM) r.p = rm;
                    else begin
                        r.p = q;
                        if (d < 0) r.s = rm;
                    end
                end
                pea_pkg::OP_DIVU, pea_pkg::OP_REMU: begin
                    if (b == 0) r.dz = 1'b1;
                    else if (op == pea_pkg::OP_REMU) r.p = unsigned'(a) % unsigned'(b);
                    else begin
                        r.p = unsigned'(a) / unsigned'(b);
                        if (d < 0) r.s = unsigned'(a) % unsigned'(b);
                    end
                end
                pea_pkg::OP_XOR, pea_pkg::OP_XORU: r.p = a ^ b;
                pea_pkg::OP_NEG, pea_pkg::OP_NEGU: r.p = 32'd0 - a;
                pea_pkg::OP_LI:  r.p = b;
                pea_pkg::OP_SEQ: r.p = 32'(a == b);
                pea_pkg::OP_SGE: r.p = 32'(a >= b);
                pea_pkg::OP_SGT: r.p = 32'(a > b);
                pea_pkg::OP_SLE: r.p = 32'(a <= b);
                pea_pkg::OP_SLT: r.p = 32'(a < b);
                pea_pkg::OP_SNE: r.p = 32'(a != b);
                pea_pkg::OP_B, pea_pkg::OP_J: begin
                    r.code = pea_pkg::CODE_JUMP; r.p = pea_pkg::NO_LINK; r.s = lbl;
                end
                pea_pkg::OP_JR: begin
                    r.code = pea_pkg::CODE_JUMP; r.p = pea_pkg::NO_LINK; r.s = a;
                end
                pea_pkg::OP_JAL:  begin r.code = pea_pkg::CODE_JUMP; r.p = b; r.s = lbl; end
                pea_pkg::OP_JALR: begin r.code = pea_pkg::CODE_JUMP; r.p = b; r.s = a; end
                pea_pkg::OP_LA: begin r.s = addr; r.p = addr; end
                pea_pkg::OP_LB, pea_pkg::OP_LH, pea_pkg::OP_LW: r.s = addr;
                pea_pkg::OP_SB, pea_pkg::OP_SH, pea_pkg::OP_SW: begin
                    r.code = pea_pkg::CODE_NONE; r.p = d; r.s = addr;
                end
                pea_pkg::OP_MOVE: r.p = a;
                pea_pkg::OP_MFHI: r.p = hi;
                pea_pkg::OP_MFLO: r.p = lo;
                default: begin
                    if (op >= pea_pkg::OP_BEQ && op <= pea_pkg::OP_BLTZ) begin
                        r.code = pea_pkg::CODE_JUMP;
                        r.p = pea_pkg::NO_LINK;
                        r.s = branch_cond(op, a, b) ? lbl : d;
                    end else r.code = pea_pkg::CODE_NONE;
                end
            endcase
            pending.push_back(r);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_alu_result got);
            t_alu_result want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: code %0d p %h s %h",
                       $signed(got.code), got.p, got.s);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.code !== want.code) begin
                $error("dest_code expected %0d actual %0d",
                       $signed(want.code), $signed(got.code));
                errors++;
            end
            if (got.p !== want.p) begin
                $error("primary_result expected %h actual %h", want.p, got.p);
                errors++;
            end
            if (got.s !== want.s) begin
                $error("secondary_result expected %h actual %h", want.s, got.s);
                errors++;
            end
            if (got.dz !== want.dz) begin
                $error("divide_by_zero expected %b actual %b", want.dz, got.dz);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [5:0]  i_operation = '0;
    logic signed [31:0] i_dest_field = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic signed [31:0] i_label_target = '0;
    logic signed [31:0] i_hi_value = '0;
    logic signed [31:0] i_lo_value = '0;
    wire         o_ready;
    wire         o_valid;
    wire signed [5:0]  o_dest_code;
    wire signed [31:0] o_primary_result;
    wire signed [31:0] o_secondary_result;
    wire         o_divide_by_zero;

    alu_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    pipeline_execute_alu DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watch both channels at every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_instr(i_operation, i_dest_field, i_operand_a, i_operand_b,
                              i_label_target, i_hi_value, i_lo_value);
            if (o_valid && i_ready)
                sb.check_result({o_dest_code, o_primary_result,
                                 o_secondary_result, o_divide_by_zero});
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // present one instruction and hold it until taken
    task automatic send_instr(logic [5:0] op, logic [31:0] d, logic [31:0] a,
                              logic [31:0] b, logic [31:0] lbl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_dest_field <= d;
        i_operand_a <= a;
        i_operand_b <= b;
        i_label_target <= lbl;
        i_hi_value <= $urandom;
        i_lo_value <= $urandom;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'h0;
            4: return $urandom_range(8);
            5: return -$urandom_range(8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dest();
        case ($urandom_range(5))
            0: return 32'hffffffff;
            1, 2: return $urandom_range(31);
            3: return -$urandom_range(5, 2);
            default: return $urandom;
        endcase
    endfunction

    // bubbles and unknown codes now and then
    task automatic random_phase(int n);
        logic [5:0] op;
        repeat (n) begin
            op = ($urandom_range(19) == 0)
                 ? 6'($urandom_range(63, int'(pea_pkg::OP_BUBBLE)))
                 : 6'($urandom_range(int'(pea_pkg::OP_MFLO)));
            send_instr(op, pick_dest(), pick_word(), pick_word(), pick_word());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 34;
        recv_idle_pct = 56;
        // directed corners: division edges, out of range dest, bubbles
        send_instr(pea_pkg::OP_DIV, 32'hffffffff, 32'h80000000, 32'hffffffff, 0);
        send_instr(pea_pkg::OP_REM, 5, 32'h80000000, 32'hffffffff, 0);
        send_instr(pea_pkg::OP_DIV, 3, 7, 0, 0);
        send_instr(pea_pkg::OP_DIVU, 32'hffffffff, 32'hffffffff, 0, 0);
        send_instr(pea_pkg::OP_REMU, 40, 32'hffffffff, 7, 0);
        send_instr(pea_pkg::OP_DIV, 32'hffffffff, -7, 2, 0);
        send_instr(pea_pkg::OP_MUL, 32'hffffffff, 32'h80000000, 32'h80000000, 0);
        send_instr(pea_pkg::OP_MULU, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
        send_instr(pea_pkg::OP_ADD, 31, 32'h7fffffff, 1, 0);
        send_instr(pea_pkg::OP_SUB, 32'h80000000, 32'h80000000, 1, 0);
        send_instr(pea_pkg::OP_NEG, 0, 32'h80000000, 0, 0);
        send_instr(pea_pkg::OP_BLT, 100, -1, 0, 200);
        send_instr(pea_pkg::OP_BGEZ, 100, -1, 0, 200);
        send_instr(pea_pkg::OP_JAL, 2, 32'h1234, 32'h44, 32'h400);
        send_instr(pea_pkg::OP_JR, 2, 32'h1234, 0, 0);
        send_instr(pea_pkg::OP_LW, 5, -1, 8, 32'h1000);
        send_instr(pea_pkg::OP_SW, 32'hdeadbeef, 16, 8, 32'h1000);
        send_instr(pea_pkg::OP_LA, 32, 16, -4, 0);
        send_instr(pea_pkg::OP_MFHI, 1, 0, 0, 0);
        send_instr(pea_pkg::OP_BUBBLE, 1, 1, 1, 1);
        send_instr(6'h3f, 1, 1, 1, 1);
        random_phase(RANDOM_ITEMS / 3);
        send_idle_pct = 56;
        recv_idle_pct = 34;
        random_phase(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(RANDOM_ITEMS / 3);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
